// ===== rtl/core/tcw_pkg.sv =====
// Shared types, constants and arithmetic helpers for the triclinic cell wrap.
// No dependencies; imported by tcw_derive and triclinic_cell_wrap.
`default_nettype none

package tcw_pkg;

    localparam int TermW = 41;
    localparam int OperW = 43;
    localparam int ProdW = 86;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_BOX_A_X = 3'd0;
    localparam logic [2:0] REG_BOX_B_X = 3'd1;
    localparam logic [2:0] REG_BOX_B_Y = 3'd2;
    localparam logic [2:0] REG_BOX_C_X = 3'd3;
    localparam logic [2:0] REG_BOX_C_Y = 3'd4;
    localparam logic [2:0] REG_BOX_C_Z = 3'd5;

    // Derivation steps, in execution order
    localparam logic [3:0] STEP_RECIP_A   = 4'd0;
    localparam logic [3:0] STEP_RECIP_B   = 4'd1;
    localparam logic [3:0] STEP_RECIP_C   = 4'd2;
    localparam logic [3:0] STEP_NEG_BX_R0 = 4'd3;
    localparam logic [3:0] STEP_T3        = 4'd4;
    localparam logic [3:0] STEP_BX_R1     = 4'd5;
    localparam logic [3:0] STEP_W         = 4'd6;
    localparam logic [3:0] STEP_W_R0      = 4'd7;
    localparam logic [3:0] STEP_T4        = 4'd8;
    localparam logic [3:0] STEP_NEG_CY_R1 = 4'd9;
    localparam logic [3:0] STEP_T5        = 4'd10;

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_SETUP = 4'b0010,
        D_ITER  = 4'b0100,
        D_STORE = 4'b1000
    } dstate_t;

    typedef logic [5:0][TermW-1:0] term_vec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } deriv_stat_t;

    localparam logic signed [TermW-1:0] T41_MAX = {1'b0, {(TermW-1){1'b1}}};
    localparam logic signed [TermW-1:0] T41_MIN = {1'b1, {(TermW-1){1'b0}}};

    // Clamp a wide product to the 41 bit signed range
    function automatic logic signed [TermW-1:0] sat41(input logic signed [ProdW-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[ProdW-1:TermW-1];
        all_zero = ~|v[ProdW-1:TermW-1];
        if (all_one || all_zero)
            return v[TermW-1:0];
        else
            return v[ProdW-1] ? T41_MIN : T41_MAX;
    endfunction

    // Coordinate times low 32 bits of a term (unsigned part)
    function automatic logic signed [64:0] pp_lo(input logic signed [31:0] c,
                                                 input logic signed [TermW-1:0] t);
        return 65'(c) * 65'($signed({1'b0, t[31:0]}));
    endfunction

    // Coordinate times high 9 bits of a term (signed part, weight 2^32)
    function automatic logic signed [40:0] pp_hi(input logic signed [31:0] c,
                                                 input logic signed [TermW-1:0] t);
        return 41'(c) * 41'($signed(t[TermW-1:32]));
    endfunction

    // Floor of the summed products over 2^48, low 32 bits
    function automatic logic [31:0] shift_count(
        input logic signed [64:0] lo0, input logic signed [40:0] hi0,
        input logic signed [64:0] lo1, input logic signed [40:0] hi1,
        input logic signed [64:0] lo2, input logic signed [40:0] hi2);
        logic signed [79:0] acc;
        acc = 80'(lo0) + (80'(hi0) <<< 32) + 80'(lo1) + (80'(hi1) <<< 32)
            + 80'(lo2) + (80'(hi2) <<< 32);
        return acc[79:48];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcw_if.sv =====
// Stream channel interfaces for coordinates in and wrapped coordinates out.
// No dependencies.
`default_nettype none

interface tcw_pt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               final_point;

    modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

interface tcw_pt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] wrapped_x;
    logic signed [31:0] wrapped_y;
    logic signed [31:0] wrapped_z;
    logic               final_out;

    modport source (output valid, wrapped_x, wrapped_y, wrapped_z, final_out, input ready);
    modport sink (input valid, wrapped_x, wrapped_y, wrapped_z, final_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcw_derive.sv =====
// Sequencer that derives the six inverse box terms with a serial divider and a
// serial multiplier. Depends on tcw_pkg.
`default_nettype none

module tcw_derive
    import tcw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic        [30:0] box_a_x,
    input  wire logic signed [31:0] box_b_x,
    input  wire logic        [30:0] box_b_y,
    input  wire logic signed [31:0] box_c_x,
    input  wire logic signed [31:0] box_c_y,
    input  wire logic        [30:0] box_c_z,
    output term_vec_t               terms,
    output deriv_stat_t             stat
);

    localparam logic [5:0] LastDivBit = 6'd48;
    localparam logic [5:0] LastMulBit = 6'd42;

    dstate_t state_reg;
    logic [3:0] step_reg;
    logic [5:0] cnt_reg;

    logic        [48:0] dnum_reg;
    logic        [48:0] dquo_reg;
    logic        [31:0] drem_reg;
    logic        [30:0] ddiv_reg;

    logic signed [ProdW-1:0] mcand_reg;
    logic signed [ProdW-1:0] acc_reg;
    logic        [OperW-1:0] mplier_reg;
    logic signed [OperW-1:0] m_reg;
    logic signed [TermW-1:0] term_reg [6];

    logic                    is_div;
    logic        [30:0]      dv_sel;
    logic signed [OperW-1:0] opa;
    logic signed [OperW-1:0] opb;
    logic        [31:0]      rem_sh;
    logic                    rem_ge;
    logic signed [ProdW-1:0] addend;
    logic signed [ProdW-1:0] shifted;
    logic signed [TermW-1:0] quo_sat;
    logic signed [TermW-1:0] mul_sat;
    logic                    last_bit;

    assign is_div = (step_reg < STEP_NEG_BX_R0);

    // Select divisor and multiply operands for the current step
    always_comb
    begin
        case (step_reg)
            STEP_RECIP_B: dv_sel = box_b_y;
            STEP_RECIP_C: dv_sel = box_c_z;
            default:      dv_sel = box_a_x;
        endcase
        opa = m_reg;
        opb = OperW'(term_reg[0]);
        case (step_reg)
            STEP_NEG_BX_R0:
            begin
                opa = -OperW'(box_b_x);
                opb = OperW'(term_reg[0]);
            end
            STEP_T3:        opb = OperW'(term_reg[1]);
            STEP_BX_R1:
            begin
                opa = OperW'(box_b_x);
                opb = OperW'(term_reg[1]);
            end
            STEP_W:         opb = OperW'(box_c_y);
            STEP_W_R0:      opb = OperW'(term_reg[0]);
            STEP_T4:        opb = OperW'(term_reg[2]);
            STEP_NEG_CY_R1:
            begin
                opa = -OperW'(box_c_y);
                opb = OperW'(term_reg[1]);
            end
            STEP_T5:        opb = OperW'(term_reg[2]);
            default:        opb = OperW'(term_reg[0]);
        endcase
    end

    // Datapath for one iteration and for the result write
    always_comb
    begin
        rem_sh   = {drem_reg[30:0], dnum_reg[48]};
        rem_ge   = (rem_sh >= {1'b0, ddiv_reg});
        addend   = mplier_reg[0] ? mcand_reg : '0;
        last_bit = is_div ? (cnt_reg == LastDivBit) : (cnt_reg == LastMulBit);
        case (step_reg)
            STEP_NEG_BX_R0, STEP_BX_R1, STEP_W_R0, STEP_NEG_CY_R1: shifted = acc_reg >>> 16;
            default:                                               shifted = acc_reg >>> 32;
        endcase
        mul_sat = sat41(shifted);
        if (ddiv_reg == '0)
            quo_sat = '0;
        else if (dquo_reg > 49'(T41_MAX))
            quo_sat = T41_MAX;
        else
            quo_sat = dquo_reg[TermW-1:0];
    end

    // Control: step through divisions, then the multiply chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= STEP_RECIP_A;
            cnt_reg   <= '0;
            for (int i = 0; i < 6; i++)
                term_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_SETUP;
                        step_reg  <= STEP_RECIP_A;
                    end
                end
                D_SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= D_ITER;
                end
                D_ITER:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (last_bit)
                        state_reg <= D_STORE;
                end
                D_STORE:
                begin
                    if (is_div)
                        term_reg[step_reg[2:0]] <= quo_sat;
                    else if (step_reg == STEP_T3)
                        term_reg[3] <= mul_sat;
                    else if (step_reg == STEP_T4)
                        term_reg[4] <= mul_sat;
                    else if (step_reg == STEP_T5)
                        term_reg[5] <= mul_sat;
                    if (step_reg == STEP_T5)
                        state_reg <= D_IDLE;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= D_SETUP;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // Divider and multiplier working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_SETUP:
            begin
                ddiv_reg   <= dv_sel;
                dnum_reg   <= (49'd1 << 48) + 49'(dv_sel >> 1);
                drem_reg   <= '0;
                dquo_reg   <= '0;
                mcand_reg  <= ProdW'(opa);
                mplier_reg <= opb;
                acc_reg    <= '0;
            end
            D_ITER:
            begin
                if (is_div)
                begin
                    dnum_reg <= {dnum_reg[47:0], 1'b0};
                    drem_reg <= rem_ge ? (rem_sh - {1'b0, ddiv_reg}) : rem_sh;
                    dquo_reg <= {dquo_reg[47:0], rem_ge};
                end
                else
                begin
                    acc_reg    <= (cnt_reg == LastMulBit) ? acc_reg - addend : acc_reg + addend;
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            D_STORE:
            begin
                if (step_reg == STEP_W)
                    m_reg <= OperW'(shifted) - OperW'(box_c_x);
                else if (!is_div)
                    m_reg <= OperW'(mul_sat);
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            terms[i] = term_reg[i];
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = (state_reg == D_STORE) && (step_reg == STEP_T5);

endmodule

`default_nettype wire

// ===== rtl/core/triclinic_cell_wrap.sv =====
// Top level of the triclinic cell wrap: APB box registers, run-start control
// and the 12 stage wrap pipeline. Depends on tcw_pkg, tcw_if and tcw_derive.
`default_nettype none

// Wraps one signed Q16.16 point per clock into the central cell of a
// lower-triangular box. Each point passes through a 12 stage pipeline (c, then
// b, then a vector removal; each as product, floor, multiply, subtract), and its
// result is presented from the last stage, held there while the sink stalls; one
// point per cycle is sustained when the sink keeps up. On the first point after
// reset or after a point marked final_point, the block first drains the pipeline
// and then runs the inverse term derivation: three 49 step reciprocal divisions
// and eight 43 step serial multiplies, during which no point is taken. Box
// registers may be written over APB only while the block is idle.
module triclinic_cell_wrap
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tcw_pt_in_if.sink        pt_in,
    tcw_pt_out_if.source     pt_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int NumStages = 12;

    logic        [30:0] box_a_x_reg;
    logic signed [31:0] box_b_x_reg;
    logic        [30:0] box_b_y_reg;
    logic signed [31:0] box_c_x_reg;
    logic signed [31:0] box_c_y_reg;
    logic        [30:0] box_c_z_reg;

    logic               run_start_reg;
    logic [NumStages-1:0] v_reg;
    logic               adv;
    logic               in_acc;
    logic               pipe_empty;
    logic               start;
    term_vec_t          terms;
    deriv_stat_t        dstat;
    logic               wr_en;

    logic signed [31:0] x_reg [NumStages];
    logic signed [31:0] y_reg [NumStages];
    logic signed [31:0] z_reg [NumStages];
    logic               f_reg [NumStages];

    logic signed [64:0] lo_a_reg [3];
    logic signed [40:0] hi_a_reg [3];
    logic        [31:0] s_reg;
    logic        [31:0] m0_reg;
    logic        [31:0] m1_reg;
    logic        [31:0] m2_reg;

    logic        [31:0] s5_reg;
    logic        [31:0] s9_reg;
    logic        [31:0] mb0_reg;
    logic        [31:0] mb1_reg;
    logic        [31:0] ma_reg;
    logic signed [64:0] lo_b_reg [3];
    logic signed [40:0] hi_b_reg [3];

    // APB register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_a_x_reg <= 31'd65536;
            box_b_x_reg <= '0;
            box_b_y_reg <= 31'd65536;
            box_c_x_reg <= '0;
            box_c_y_reg <= '0;
            box_c_z_reg <= 31'd65536;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_BOX_A_X: box_a_x_reg <= pwdata[30:0];
                REG_BOX_B_X: box_b_x_reg <= pwdata;
                REG_BOX_B_Y: box_b_y_reg <= pwdata[30:0];
                REG_BOX_C_X: box_c_x_reg <= pwdata;
                REG_BOX_C_Y: box_c_y_reg <= pwdata;
                REG_BOX_C_Z: box_c_z_reg <= pwdata[30:0];
                default:     box_a_x_reg <= box_a_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BOX_A_X: prdata = {1'b0, box_a_x_reg};
            REG_BOX_B_X: prdata = box_b_x_reg;
            REG_BOX_B_Y: prdata = {1'b0, box_b_y_reg};
            REG_BOX_C_X: prdata = box_c_x_reg;
            REG_BOX_C_Y: prdata = box_c_y_reg;
            REG_BOX_C_Z: prdata = {1'b0, box_c_z_reg};
            default:     prdata = '0;
        endcase
    end

    // Run-start control: derive terms once the pipeline is empty
    assign adv         = !v_reg[NumStages-1] || pt_out.ready;
    assign pt_in.ready = adv && !run_start_reg;
    assign in_acc      = pt_in.valid && pt_in.ready;
    assign pipe_empty  = ~|v_reg;
    assign start       = run_start_reg && pt_in.valid && pipe_empty && !dstat.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_start_reg <= 1'b1;
        else if (dstat.done)
            run_start_reg <= 1'b0;
        else if (in_acc && pt_in.final_point)
            run_start_reg <= 1'b1;
    end

    tcw_derive u_derive (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .box_a_x (box_a_x_reg),
        .box_b_x (box_b_x_reg),
        .box_b_y (box_b_y_reg),
        .box_c_x (box_c_x_reg),
        .box_c_y (box_c_y_reg),
        .box_c_z (box_c_z_reg),
        .terms   (terms),
        .stat    (dstat)
    );

    // Advance valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NumStages-2:0], in_acc};
    end

    // Wrap datapath; every stage holds while the output stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k < NumStages; k++)
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
                z_reg[k] <= z_reg[k-1];
                f_reg[k] <= f_reg[k-1];
            end
            // Stage 0: take the point, form z times 1/cz
            x_reg[0] <= pt_in.pos_x;
            y_reg[0] <= pt_in.pos_y;
            z_reg[0] <= pt_in.pos_z;
            f_reg[0] <= pt_in.final_point;
            lo_a_reg[0] <= pp_lo(pt_in.pos_z, $signed(terms[2]));
            hi_a_reg[0] <= pp_hi(pt_in.pos_z, $signed(terms[2]));
            // Stage 1: c shift count
            s_reg <= shift_count(lo_a_reg[0], hi_a_reg[0], '0, '0, '0, '0);
            // Stage 2: shift times c vector
            m0_reg <= 32'(s_reg * {1'b0, box_c_z_reg});
            m1_reg <= 32'(s_reg * box_c_y_reg);
            m2_reg <= 32'(s_reg * box_c_x_reg);
            // Stage 3: remove c vectors
            z_reg[3] <= z_reg[2] - m0_reg;
            y_reg[3] <= y_reg[2] - m1_reg;
            x_reg[3] <= x_reg[2] - m2_reg;
            // Stage 4: b fraction products
            lo_a_reg[1] <= pp_lo(y_reg[3], $signed(terms[1]));
            hi_a_reg[1] <= pp_hi(y_reg[3], $signed(terms[1]));
            lo_a_reg[2] <= pp_lo(z_reg[3], $signed(terms[5]));
            hi_a_reg[2] <= pp_hi(z_reg[3], $signed(terms[5]));
            // Stage 5: b shift count
            s5_reg <= shift_count(lo_a_reg[1], hi_a_reg[1], lo_a_reg[2], hi_a_reg[2],
                                  '0, '0);
            // Stage 6: shift times b vector
            mb0_reg <= 32'(s5_reg * {1'b0, box_b_y_reg});
            mb1_reg <= 32'(s5_reg * box_b_x_reg);
            // Stage 7: remove b vectors
            y_reg[7] <= y_reg[6] - mb0_reg;
            x_reg[7] <= x_reg[6] - mb1_reg;
            // Stage 8: a fraction products
            lo_b_reg[0] <= pp_lo(x_reg[7], $signed(terms[0]));
            hi_b_reg[0] <= pp_hi(x_reg[7], $signed(terms[0]));
            lo_b_reg[1] <= pp_lo(y_reg[7], $signed(terms[3]));
            hi_b_reg[1] <= pp_hi(y_reg[7], $signed(terms[3]));
            lo_b_reg[2] <= pp_lo(z_reg[7], $signed(terms[4]));
            hi_b_reg[2] <= pp_hi(z_reg[7], $signed(terms[4]));
            // Stage 9: a shift count
            s9_reg <= shift_count(lo_b_reg[0], hi_b_reg[0], lo_b_reg[1], hi_b_reg[1],
                                  lo_b_reg[2], hi_b_reg[2]);
            // Stage 10: shift times a vector
            ma_reg <= 32'(s9_reg * {1'b0, box_a_x_reg});
            // Stage 11: remove a vectors
            x_reg[11] <= x_reg[10] - ma_reg;
        end
    end

    // Present the last stage
    assign pt_out.valid     = v_reg[NumStages-1];
    assign pt_out.wrapped_x = x_reg[NumStages-1];
    assign pt_out.wrapped_y = y_reg[NumStages-1];
    assign pt_out.wrapped_z = z_reg[NumStages-1];
    assign pt_out.final_out = f_reg[NumStages-1];

`ifndef ASSERT_OFF
    a_no_take_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_in.valid && pt_in.ready) |-> !dstat.busy)
        else $error("point transfer while inverse terms are being derived");

    a_derive_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dstat.busy) |-> $past(pipe_empty))
        else $error("term derivation started with points in flight");

    a_run_open_after_derive: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |=> !run_start_reg)
        else $error("run start still pending after derivation");
`endif

endmodule

`default_nettype wire
